// File: src/nrw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrw_pkg
// Shared widths and codes of the name registry.
// ----------------------------------------------------------------------------
package nrw_pkg;

	localparam int TASK_W = 5;
	localparam int NAME_W = 64;

	typedef enum logic {
		OP_REGISTER = 1'b0,
		OP_LOOKUP   = 1'b1
	} op_t;

	typedef enum logic {
		KIND_ACK    = 1'b0,
		KIND_ANSWER = 1'b1
	} kind_t;

	typedef enum logic {
		STAT_OK   = 1'b0,
		STAT_FULL = 1'b1
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ESCAN,
		S_WSCAN,
		S_REPLY
	} state_t;

endpackage
`default_nettype wire

// File: src/nrw_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrw_req_if
// Request channel: operation, requesting task and name key.
// ----------------------------------------------------------------------------
interface nrw_req_if;
	import nrw_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [TASK_W-1:0] requester;
	logic [NAME_W-1:0] name_key;

	modport source (output valid, op, requester, name_key, input ready);
	modport sink   (input valid, op, requester, name_key, output ready);
endinterface
`default_nettype wire

// File: src/nrw_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrw_rsp_if
// Reply channel: destination task, reply kind, answer, status and last flag.
// ----------------------------------------------------------------------------
interface nrw_rsp_if;
	import nrw_pkg::*;

	logic              valid;
	logic              ready;
	logic [TASK_W-1:0] dest_task;
	logic              reply_kind;
	logic [TASK_W-1:0] answer_task;
	logic              status;
	logic              last;

	modport source (output valid, dest_task, reply_kind, answer_task, status, last,
		input ready);
	modport sink   (input valid, dest_task, reply_kind, answer_task, status, last,
		output ready);
endinterface
`default_nettype wire

// File: src/nrw_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrw_out_reg
// One-deep reply register between the sequencer and the reply channel.
// ----------------------------------------------------------------------------
module nrw_out_reg (
	input  wire        clk,
	input  wire        arst_n,
	nrw_rsp_if.sink    up,
	nrw_rsp_if.source  dn
);
	import nrw_pkg::*;

	logic              v_q;
	logic [TASK_W-1:0] dest_q;
	logic              kind_q;
	logic [TASK_W-1:0] ans_q;
	logic              status_q;
	logic              last_q;
	logic              load;

	assign up.ready = !v_q || dn.ready;
	assign load     = up.valid && up.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load) begin
			v_q <= 1'b1;
		end else if (dn.ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dest_q   <= up.dest_task;
			kind_q   <= up.reply_kind;
			ans_q    <= up.answer_task;
			status_q <= up.status;
			last_q   <= up.last;
		end
	end

	assign dn.valid       = v_q;
	assign dn.dest_task   = dest_q;
	assign dn.reply_kind  = kind_q;
	assign dn.answer_task = ans_q;
	assign dn.status      = status_q;
	assign dn.last        = last_q;
endmodule
`default_nettype wire

// File: src/nrw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrw_ctrl
// Request sequencer with entry and waiter memories: entry scan, update,
// waiter scan and wake-up replies.
// ----------------------------------------------------------------------------
module nrw_ctrl #(
	parameter int TASK_SLOTS = 32,
	parameter int NAME_BYTES = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	nrw_req_if.sink    req,
	nrw_rsp_if.source  rsp
);
	import nrw_pkg::*;

	localparam int IW = $clog2(TASK_SLOTS);
	localparam int CW = $clog2(TASK_SLOTS + 1);
	localparam int NW = 8 * NAME_BYTES;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [TASK_W-1:0] req_q;
	logic [NW-1:0]     name_q;
	logic [NW-1:0]     name_norm;
	logic              alive;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic              rv_s1, rv_d;
	logic [IW-1:0]     ridx_s1;
	logic [TASK_SLOTS-1:0] flags_q;

	logic [TASK_W-1:0] rep_dest_q;
	kind_t             rep_kind_q;
	logic [TASK_W-1:0] rep_ans_q;
	status_t           rep_status_q;

	logic [NW-1:0]     ent_name_mem [TASK_SLOTS];
	logic [TASK_W-1:0] ent_task_mem [TASK_SLOTS];
	logic [NW-1:0]     wt_name_mem  [TASK_SLOTS];
	logic [NW-1:0]     ent_name_rd_s1;
	logic [TASK_W-1:0] ent_task_rd_s1;
	logic [NW-1:0]     wt_name_rd_s1;

	logic              accept;
	logic              full;
	logic              e_hit, e_issue, e_done;
	logic              w_hit, w_stall, w_issue, w_done;
	logic              do_append, do_overwrite, do_wait;
	logic [IW-1:0]     ent_waddr;

	// Name normalisation: keep bytes up to the first zero byte.
	always_comb begin
		alive     = 1'b1;
		name_norm = '0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (req.name_key[8*b +: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				name_norm[8*b +: 8] = req.name_key[8*b +: 8];
			end
		end
	end

	// Outputs and datapath control
	always_comb begin
		accept    = (state_q == S_IDLE) && req.valid;
		req.ready = (state_q == S_IDLE);
		full      = (count_q == CW'(TASK_SLOTS));

		e_hit   = (state_q == S_ESCAN) && rv_s1 && (ent_name_rd_s1 == name_q);
		e_issue = (state_q == S_ESCAN) && !e_hit && (idx_q < count_q);
		e_done  = (state_q == S_ESCAN) && (e_hit || (!rv_s1 && (idx_q >= count_q)));

		w_hit   = (state_q == S_WSCAN) && rv_s1 && flags_q[ridx_s1] &&
			(wt_name_rd_s1 == name_q);
		w_stall = w_hit && !rsp.ready;
		w_issue = (state_q == S_WSCAN) && !w_stall && (idx_q < CW'(TASK_SLOTS));
		w_done  = (state_q == S_WSCAN) && !rv_s1 && (idx_q == CW'(TASK_SLOTS));

		do_overwrite = e_done && (op_q == OP_REGISTER) && e_hit;
		do_append    = e_done && (op_q == OP_REGISTER) && !e_hit && !full;
		do_wait      = e_done && (op_q == OP_LOOKUP) && !e_hit &&
			(32'(req_q) < TASK_SLOTS);
		ent_waddr    = e_hit ? ridx_s1 : count_q[IW-1:0];

		case (state_q)
			S_ESCAN: rv_d = e_issue;
			S_WSCAN: rv_d = w_stall ? rv_s1 : w_issue;
			default: rv_d = 1'b0;
		endcase

		rsp.valid       = 1'b0;
		rsp.dest_task   = rep_dest_q;
		rsp.reply_kind  = rep_kind_q;
		rsp.answer_task = rep_ans_q;
		rsp.status      = rep_status_q;
		rsp.last        = 1'b1;
		case (state_q)
			S_WSCAN: begin
				rsp.valid       = w_hit;
				rsp.dest_task   = TASK_W'(ridx_s1);
				rsp.reply_kind  = KIND_ANSWER;
				rsp.answer_task = req_q;
				rsp.status      = STAT_OK;
				rsp.last        = 1'b0;
			end
			S_REPLY: begin
				rsp.valid = 1'b1;
			end
			default: begin
				rsp.valid = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_ESCAN;
			end
			S_ESCAN: begin
				if (e_done) begin
					if (do_append) begin
						state_d = S_WSCAN;
					end else if (op_q == OP_LOOKUP && !e_hit) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_REPLY;
					end
				end
			end
			S_WSCAN: begin
				if (w_done) state_d = S_REPLY;
			end
			S_REPLY: begin
				if (rsp.ready) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rv_s1   <= 1'b0;
			idx_q   <= '0;
			count_q <= '0;
			flags_q <= '0;
		end else begin
			state_q <= state_d;
			rv_s1   <= rv_d;
			if (accept || do_append) begin
				idx_q <= '0;
			end else if (e_issue || w_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (do_append) begin
				count_q <= count_q + 1'b1;
			end
			if (do_wait) begin
				flags_q[IW'(req_q)] <= 1'b1;
			end
			if (w_hit && rsp.ready) begin
				flags_q[ridx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_t'(req.op);
			req_q  <= req.requester;
			name_q <= name_norm;
		end
		if (e_issue || w_issue) begin
			ridx_s1 <= idx_q[IW-1:0];
		end
		if (e_done) begin
			rep_dest_q   <= req_q;
			rep_kind_q   <= (op_q == OP_LOOKUP) ? KIND_ANSWER : KIND_ACK;
			rep_ans_q    <= (op_q == OP_LOOKUP) ? ent_task_rd_s1 : '0;
			rep_status_q <= (op_q == OP_REGISTER && !e_hit && full) ? STAT_FULL : STAT_OK;
		end
	end

	// Entry memories
	always_ff @(posedge clk) begin
		if (do_append) begin
			ent_name_mem[ent_waddr] <= name_q;
		end
		if (do_append || do_overwrite) begin
			ent_task_mem[ent_waddr] <= req_q;
		end
		if (e_issue) begin
			ent_name_rd_s1 <= ent_name_mem[idx_q[IW-1:0]];
			ent_task_rd_s1 <= ent_task_mem[idx_q[IW-1:0]];
		end
	end

	// Waiter name memory
	always_ff @(posedge clk) begin
		if (do_wait) begin
			wt_name_mem[IW'(req_q)] <= name_q;
		end
		if (w_issue) begin
			wt_name_rd_s1 <= wt_name_mem[idx_q[IW-1:0]];
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TASK_SLOTS))
		else $error("entry count beyond table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
		else $error("entry count moved by more than one");

	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_append |-> !full)
		else $error("append into a full table");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (state_q == S_ESCAN || state_q == S_WSCAN))
		else $error("pending memory read outside a scan");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_ESCAN && !rv_s1 && idx_q == '0))
		else $error("scan did not start cleanly after a request");
`endif
endmodule
`default_nettype wire

// File: src/name_registry_with_waiters.sv
`default_nettype none
// ----------------------------------------------------------------------------
// name_registry_with_waiters
// Name-to-task registry with blocked look-ups.
// ----------------------------------------------------------------------------
// req carries one transaction per request: op (register / look up), the
// requesting task and a packed name key. rsp carries the replies; last marks
// the final reply of a request. A look-up that misses gives no reply and
// blocks the requester on that name; a later register that stores the name
// wakes it. A request is taken only while the sequencer is idle. Each
// request is accepted, then runs an entry scan over the N stored entries
// that ends at the first match (one memory read per cycle, registered
// reads). A register that appends adds a waiter scan over all TASK_SLOTS
// waiter slots; woken waiters are answered during the scan at no extra
// cost while rsp is ready. Then the acknowledge.
// Replies leave through a one-deep output register that registers each
// reply the sequencer issues; while rsp.ready is low the sequencer stops at
// the next reply it has to issue and the request channel stalls behind it.
// Reset clears the entry count and the waiter flags; the name and task
// memories need no clearing pass.
// ----------------------------------------------------------------------------
module name_registry_with_waiters #(
	parameter int TASK_SLOTS = 32,
	parameter int NAME_BYTES = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	nrw_req_if.sink    req,
	nrw_rsp_if.source  rsp
);
	nrw_rsp_if ctrl_rsp ();

	nrw_ctrl #(
		.TASK_SLOTS (TASK_SLOTS),
		.NAME_BYTES (NAME_BYTES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (ctrl_rsp.source)
	);

	nrw_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.up     (ctrl_rsp.sink),
		.dn     (rsp)
	);
endmodule
`default_nettype wire

// File: dv/tb_name_registry_with_waiters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_name_registry_with_waiters
// Self-checking bench for the name registry with blocked look-ups.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first. It covers misses that block,
// wake-up order, overwrites, names that differ only after their first zero
// byte, the empty name, all-ones keys and a waiter slot that is re-targeted.
// Random traffic follows. Part of it blocks tasks on a name that is not yet
// stored, then registers that name, so that waiters are woken. The rest is
// look-ups and overwrites of stored names and raw random keys. The table fills
// up along the way, so later appends return the full status. Every reply is
// checked against a local model of the registry, or against the typed reply
// of a table row.
// ----------------------------------------------------------------------------
module tb_name_registry_with_waiters;
	import nrw_pkg::*;

	localparam int SLOTS        = 32;
	localparam int RANDOM_ITEMS = 440;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 120;
	localparam int WATCH_LIMIT  = 3000;

	typedef struct packed {
		logic [TASK_W-1:0] dest;
		kind_t             kind;
		logic [TASK_W-1:0] ans;
		status_t           st;
		logic              last;
	} reply_t;

	typedef struct packed {
		op_t               op;
		logic [TASK_W-1:0] who;
		logic [NAME_W-1:0] key;
		logic              fixed;
		reply_t            exp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	nrw_req_if req_ch ();
	nrw_rsp_if rsp_ch ();

	name_registry_with_waiters dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #6 clk = ~clk;

	logic [NAME_W-1:0] entry_names [SLOTS];
	logic [TASK_W-1:0] entry_tasks [SLOTS];
	int                entry_count;
	logic [NAME_W-1:0] waiter_names [SLOTS];
	logic              waiter_flags [SLOTS];

	reply_t    predicted [$];
	reply_t    expected_replies [$];
	stim_row_t stim_rows [$];

	int mismatches    = 0;
	int tx_idle_pct   = 15;
	int rx_idle_pct   = 15;
	bit calm          = 1'b0;
	bit stall_request = 1'b0;

	function automatic reply_t mk_reply(logic [TASK_W-1:0] dest, kind_t kind,
		logic [TASK_W-1:0] ans, status_t st, logic last);
		reply_t r;
		r.dest = dest;
		r.kind = kind;
		r.ans  = ans;
		r.st   = st;
		r.last = last;
		return r;
	endfunction

	function automatic stim_row_t mk_row(op_t op, logic [TASK_W-1:0] who,
		logic [NAME_W-1:0] key, logic fixed, reply_t exp);
		stim_row_t r;
		r.op    = op;
		r.who   = who;
		r.key   = key;
		r.fixed = fixed;
		r.exp   = exp;
		return r;
	endfunction

	// name ends at its first zero byte
	function automatic logic [NAME_W-1:0] name_norm(logic [NAME_W-1:0] key);
		logic [NAME_W-1:0] nm;
		bit                done;
		nm   = '0;
		done = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (key[8*b +: 8] == 8'h00)
				done = 1'b1;
			if (!done)
				nm[8*b +: 8] = key[8*b +: 8];
		end
		return nm;
	endfunction

	// garbage above the terminating zero byte must not change the name
	function automatic logic [NAME_W-1:0] dress_name(logic [NAME_W-1:0] nm);
		logic [NAME_W-1:0] key;
		int                len;
		bit                done;
		key  = nm;
		len  = 8;
		done = 1'b0;
		for (int b = 0; b < 8; b++) begin
			if (!done && nm[8*b +: 8] == 8'h00) begin
				done = 1'b1;
				len  = b;
			end
		end
		if (len < 7 && $urandom_range(0, 1) == 1)
			for (int b = len + 1; b < 8; b++)
				key[8*b +: 8] = 8'($urandom);
		return key;
	endfunction

	function automatic logic [NAME_W-1:0] new_name();
		logic [NAME_W-1:0] nm;
		int                len;
		nm  = '0;
		len = $urandom_range(1, 8);
		for (int b = 0; b < len; b++)
			nm[8*b +: 8] = 8'($urandom_range(1, 255));
		return nm;
	endfunction

	function automatic void registry_predict(op_t op, logic [TASK_W-1:0] who,
		logic [NAME_W-1:0] key);
		logic [NAME_W-1:0] nm;
		int                hit;
		nm  = name_norm(key);
		hit = -1;
		for (int i = 0; i < entry_count; i++)
			if (hit < 0 && entry_names[i] == nm)
				hit = i;
		if (op == OP_REGISTER) begin
			if (hit >= 0) begin
				entry_tasks[hit] = who;
				predicted.push_back(mk_reply(who, KIND_ACK, '0, STAT_OK, 1'b1));
			end else if (entry_count >= SLOTS) begin
				predicted.push_back(mk_reply(who, KIND_ACK, '0, STAT_FULL, 1'b1));
			end else begin
				entry_names[entry_count] = nm;
				entry_tasks[entry_count] = who;
				entry_count++;
				for (int i = 0; i < SLOTS; i++) begin
					if (waiter_flags[i] && waiter_names[i] == nm) begin
						waiter_flags[i] = 1'b0;
						predicted.push_back(mk_reply(5'(i), KIND_ANSWER, who,
							STAT_OK, 1'b0));
					end
				end
				predicted.push_back(mk_reply(who, KIND_ACK, '0, STAT_OK, 1'b1));
			end
		end else if (hit >= 0) begin
			predicted.push_back(mk_reply(who, KIND_ANSWER, entry_tasks[hit],
				STAT_OK, 1'b1));
		end else begin
			waiter_names[who] = nm;
			waiter_flags[who] = 1'b1;
		end
	endfunction

	task automatic send_row(stim_row_t row);
		if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.op        <= row.op;
		req_ch.requester <= row.who;
		req_ch.name_key  <= row.key;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		registry_predict(row.op, row.who, row.key);
		if (row.fixed)
			expected_replies.push_back(row.exp);
		else
			foreach (predicted[i])
				expected_replies.push_back(predicted[i]);
		predicted.delete();
	endtask

	always @(posedge clk) begin : check_reply
		reply_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected reply transaction to task %0d", rsp_ch.dest_task);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_ch.dest_task !== want.dest) begin
					$error("dest_task: expected %0d, got %0d", want.dest, rsp_ch.dest_task);
					mismatches++;
				end
				if (rsp_ch.reply_kind !== want.kind) begin
					$error("reply_kind: expected %0d, got %0d", want.kind,
						rsp_ch.reply_kind);
					mismatches++;
				end
				if (rsp_ch.answer_task !== want.ans) begin
					$error("answer_task: expected %0d, got %0d", want.ans,
						rsp_ch.answer_task);
					mismatches++;
				end
				if (rsp_ch.status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp_ch.last);
					mismatches++;
				end
			end
		end
	end

	initial begin : reply_sink
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCH_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		stim_row_t         row;
		logic [NAME_W-1:0] fresh_name;
		int                roll;
		int                pcts [3];

		pcts = '{0, 15, 50};
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.op        <= OP_REGISTER;
		req_ch.requester <= '0;
		req_ch.name_key  <= '0;
		entry_count = 0;
		for (int i = 0; i < SLOTS; i++)
			waiter_flags[i] = 1'b0;

		// two blocked on "A", then one on the empty name
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd3, 64'h41, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd31, 64'h41, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd5, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd7, 64'h41, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd0, 64'h41, 1'b1,
			mk_reply(5'd0, KIND_ANSWER, 5'd7, STAT_OK, 1'b1)));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd31, 64'h0000_DEAD_BE00_0041, 1'b1,
			mk_reply(5'd31, KIND_ACK, 5'd0, STAT_OK, 1'b1)));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd1, 64'hFFFF_FFFF_FFFF_0041, 1'b1,
			mk_reply(5'd1, KIND_ANSWER, 5'd31, STAT_OK, 1'b1)));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd0, '1, 1'b1,
			mk_reply(5'd0, KIND_ACK, 5'd0, STAT_OK, 1'b1)));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd31, '1, 1'b1,
			mk_reply(5'd31, KIND_ANSWER, 5'd0, STAT_OK, 1'b1)));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd9, 64'h0, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd16, 64'h0, 1'b1,
			mk_reply(5'd16, KIND_ANSWER, 5'd9, STAT_OK, 1'b1)));
		// task 12 moves its wait from "B" to "C"
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd12, 64'h42, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd12, 64'h43, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd2, 64'h42, 1'b1,
			mk_reply(5'd2, KIND_ACK, 5'd0, STAT_OK, 1'b1)));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd4, 64'h43, 1'b0, '0));
		// wake order is ascending waiter index
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd30, 64'h8080_8080_8080_8080, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd20, 64'h8080_8080_8080_8080, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd0, 64'h8080_8080_8080_8080, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd17, 64'h8080_8080_8080_8080, 1'b0, '0));
		// a task woken by its own register
		stim_rows.push_back(mk_row(OP_LOOKUP, 5'd11, 64'h44, 1'b0, '0));
		stim_rows.push_back(mk_row(OP_REGISTER, 5'd11, 64'h44, 1'b0, '0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_row(stim_rows[i]);

		fresh_name = new_name();
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 40 == 0) begin
				tx_idle_pct = pcts[$urandom_range(0, 2)];
				rx_idle_pct = pcts[$urandom_range(0, 2)];
			end
			if (k == 120)
				stall_request = 1'b1;
			if (k == 250) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				while (expected_replies.size() != 0)
					@(posedge clk);
			end
			if (k == 380)
				calm = 1'b1;
			roll = $urandom_range(0, 99);
			row = '0;
			row.who = 5'($urandom_range(0, 31));
			if (roll < 40 && entry_count != 0) begin
				row.op  = OP_LOOKUP;
				row.key = dress_name(entry_names[$urandom_range(0, entry_count - 1)]);
			end else if (roll < 55 && entry_count != 0) begin
				row.op  = OP_REGISTER;
				row.key = dress_name(entry_names[$urandom_range(0, entry_count - 1)]);
			end else if (roll < 75) begin
				row.op  = OP_LOOKUP;
				row.key = dress_name(fresh_name);
			end else if (roll < 87) begin
				row.op     = OP_REGISTER;
				row.key    = dress_name(fresh_name);
				fresh_name = new_name();
			end else if (roll < 97) begin
				row.op  = OP_LOOKUP;
				row.key = {$urandom, $urandom};
			end else begin
				row.op  = OP_REGISTER;
				row.key = {$urandom, $urandom};
			end
			send_row(row);
		end
		req_ch.valid <= 1'b0;

		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_replies.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
src/nrw_pkg.sv
src/nrw_req_if.sv
src/nrw_rsp_if.sv
src/nrw_out_reg.sv
src/nrw_ctrl.sv
src/name_registry_with_waiters.sv
dv/tb_name_registry_with_waiters.sv
